// ===== hdl/acgc_pkg.sv =====
// Shared types, constants and conversion functions for the cursor glide controller.
package acgc_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned FINE_W     = COORD_BITS + FRAC_BITS;
  localparam int unsigned DIFF_W     = FINE_W + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [FINE_W-1:0]     fine_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;

  localparam diff_t ONE_PX     = diff_t'(1) <<< FRAC_BITS;
  localparam diff_t NEG_ONE_PX = -ONE_PX;

  // Register map, one word per register.
  typedef enum logic [1:0] {
    REG_PATTERN_COUNT = 2'd0,
    REG_ANIM_SPEED    = 2'd1,
    REG_HOTSPOT_X     = 2'd2,
    REG_HOTSPOT_Y     = 2'd3
  } reg_idx_e;

  localparam logic ACTION_TICK  = 1'b0;
  localparam logic ACTION_GLIDE = 1'b1;

  // Bit positions inside button_flags.
  localparam int unsigned FLAG_LEFT_HELD  = 0;
  localparam int unsigned FLAG_RIGHT_HELD = 1;
  localparam int unsigned FLAG_LEFT_DOWN  = 2;
  localparam int unsigned FLAG_LEFT_UP    = 3;
  localparam int unsigned FLAG_RIGHT_DOWN = 4;
  localparam int unsigned FLAG_RIGHT_UP   = 5;

  typedef struct packed {
    logic [7:0]         pattern_count;
    logic signed [7:0]  anim_speed;
    logic signed [15:0] hotspot_x;
    logic signed [15:0] hotspot_y;
  } cfg_t;

  // Wraps or sign extends a 16-bit port coordinate to the internal width.
  function automatic coord_t to_coord(logic [15:0] v);
    logic [COORD_BITS+15:0] w;
    w = {{COORD_BITS{v[15]}}, v};
    return coord_t'(w[COORD_BITS-1:0]);
  endfunction

  // Brings an internal coordinate back to the 16-bit port field.
  function automatic logic [15:0] coord_to_16(coord_t c);
    logic [COORD_BITS+15:0] w;
    w = {{16{c[COORD_BITS-1]}}, c};
    return w[15:0];
  endfunction

  // Cursor minus hotspot, kept to 17 bits.
  function automatic logic [16:0] draw_pos(coord_t c, logic [15:0] hs);
    logic [COORD_BITS+16:0] a;
    logic [COORD_BITS+16:0] b;
    logic [COORD_BITS+16:0] s;
    a = {{17{c[COORD_BITS-1]}}, c};
    b = {{(COORD_BITS+1){hs[15]}}, hs};
    s = a - b;
    return s[16:0];
  endfunction

endpackage

// ===== hdl/acgc_cfg_regs.sv =====
// APB configuration registers of the cursor glide controller.
module acgc_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output acgc_pkg::cfg_t      cfg_o,
  output logic                restart_o
);
  import acgc_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  logic     wr_en;
  reg_idx_e wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign wr_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d     = cfg_q;
    restart_o = 1'b0;
    if (wr_en) begin
      unique case (wr_idx)
        REG_PATTERN_COUNT: begin
          // A zero count is dropped without any side effect.
          if (pwdata[7:0] != 8'd0) begin
            cfg_d.pattern_count = pwdata[7:0];
            restart_o           = 1'b1;
          end
        end
        REG_ANIM_SPEED: cfg_d.anim_speed = pwdata[7:0];
        REG_HOTSPOT_X:  cfg_d.hotspot_x  = pwdata[15:0];
        REG_HOTSPOT_Y:  cfg_d.hotspot_y  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_PATTERN_COUNT: prdata = {24'd0, cfg_q.pattern_count};
      REG_ANIM_SPEED:    prdata = {24'd0, cfg_q.anim_speed};
      REG_HOTSPOT_X:     prdata = {16'd0, cfg_q.hotspot_x};
      REG_HOTSPOT_Y:     prdata = {16'd0, cfg_q.hotspot_y};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_count <= 8'd1;
      cfg_q.anim_speed    <= 8'sd0;
      cfg_q.hotspot_x     <= 16'sd0;
      cfg_q.hotspot_y     <= 16'sd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/acgc_glide_axis.sv =====
// One glide axis: halves the fixed-point gap, at least 1 px, or snaps.
module acgc_glide_axis (
  input  acgc_pkg::fine_t  fine_i,
  input  acgc_pkg::coord_t target_i,
  output acgc_pkg::fine_t  fine_o,
  output acgc_pkg::coord_t cursor_o,
  output logic             snap_o
);
  import acgc_pkg::*;

  diff_t remain;
  diff_t half;
  diff_t step;
  diff_t sum;

  always_comb begin
    remain = (diff_t'(target_i) <<< FRAC_BITS) - diff_t'(fine_i);
    // Halving that truncates toward zero.
    half = (remain + diff_t'(remain[DIFF_W-1])) >>> 1;
    step = '0;
    snap_o = 1'b0;
    if (remain > ONE_PX) begin
      step = (half > ONE_PX) ? half : ONE_PX;
    end else if (remain < NEG_ONE_PX) begin
      step = (half < NEG_ONE_PX) ? half : NEG_ONE_PX;
    end else begin
      snap_o = 1'b1;
    end
    sum = diff_t'(fine_i) + step;
    if (snap_o) begin
      // The fine position stays put; the pixel position lands on target.
      fine_o   = fine_i;
      cursor_o = target_i;
    end else begin
      fine_o   = fine_t'(sum[FINE_W-1:0]);
      cursor_o = coord_t'(sum[FINE_W-1:FRAC_BITS]);
    end
  end

endmodule

// ===== hdl/acgc_anim_step.sv =====
// Animation tick counter and pattern index stepping with wrap.
module acgc_anim_step (
  input  logic [7:0]        tick_i,
  input  logic [7:0]        pattern_i,
  input  logic signed [7:0] speed_i,
  input  logic [7:0]        count_i,
  output logic [7:0]        tick_o,
  output logic [7:0]        pattern_o
);

  logic [7:0] mag;
  logic [7:0] tick_inc;
  logic       advance;

  always_comb begin
    mag      = speed_i[7] ? 8'(-speed_i) : speed_i;
    tick_inc = tick_i + 8'd1;
    advance  = (speed_i != 8'sd0) && (tick_inc >= mag);
    tick_o   = advance ? 8'd0 : tick_inc;
    pattern_o = pattern_i;
    if (advance) begin
      // The index is always below the count, so one compare gives the wrap.
      if (!speed_i[7]) begin
        pattern_o = (pattern_i + 8'd1 == count_i) ? 8'd0 : pattern_i + 8'd1;
      end else begin
        pattern_o = (pattern_i == 8'd0) ? count_i - 8'd1 : pattern_i - 8'd1;
      end
    end
  end

endmodule

// ===== hdl/animated_cursor_glide_controller.sv =====
// Top level of the animated cursor glide controller.
//
// Items arrive on the slave stream. tuser[0] carries the action: a tick
// (0) or a glide command (1) that latches goal_x/goal_y and starts gliding.
// Each item yields exactly one result transaction on the master stream with
// the cursor position, the hotspot-corrected draw position, the animation
// pattern index, the button flags, the glide state and the warp flag.
// Registers are written through the APB port; the user must write them only
// while the block is idle, which the block itself does not enforce.
//
// An item is captured into an input register; short add, shift and compare
// logic forms the next state and result, which land in the state registers
// and the result register. One item per cycle is sustained while the receiver
// takes results, limited by the single state update per item.
//
// A stalled receiver holds the result register; one further item waits in
// the input register, and only then is s_axis_tready_o dropped.
// Reset clears all state and the registers (pattern count comes up as one).
module animated_cursor_glide_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tuser: action
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: mouse_x, mouse_y, left_level, right_level, goal_x, goal_y, zero pad
  input  logic [71:0] s_axis_tdata_i,
  input  logic [0:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: pos_x, pos_y, draw_x, draw_y, pattern_index, button_flags,
  // gliding, warp_request, zero pad
  output logic [87:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import acgc_pkg::*;

  cfg_t cfg;
  logic restart;

  acgc_cfg_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  // Input register stage.
  logic        in_valid_q;
  logic        in_action_q;
  logic [65:0] in_data_q;
  logic        out_valid_q;
  logic [81:0] out_data_q;
  logic        out_adv;
  logic        fire;

  assign out_adv         = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && out_adv;
  assign s_axis_tready_o = !in_valid_q || out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_action_q <= s_axis_tuser_i[0];
      in_data_q   <= s_axis_tdata_i[65:0];
    end
  end

  coord_t mouse_x, mouse_y, goal_x, goal_y;
  logic   left_lvl, right_lvl;

  assign mouse_x   = to_coord(in_data_q[15:0]);
  assign mouse_y   = to_coord(in_data_q[31:16]);
  assign left_lvl  = in_data_q[32];
  assign right_lvl = in_data_q[33];
  assign goal_x    = to_coord(in_data_q[49:34]);
  assign goal_y    = to_coord(in_data_q[65:50]);

  // Controller state.
  logic [7:0] tick_q, tick_d;
  logic [7:0] pattern_q, pattern_d;
  fine_t      fine_x_q, fine_x_d, fine_y_q, fine_y_d;
  coord_t     target_x_q, target_x_d, target_y_q, target_y_d;
  coord_t     cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  logic       glide_q, glide_d;
  logic       left_prev_q, left_prev_d, right_prev_q, right_prev_d;
  logic [5:0] flags_q, flags_d;
  logic       warp;

  fine_t      ax_fine_x, ax_fine_y;
  coord_t     ax_cur_x, ax_cur_y;
  logic       snap_x, snap_y;
  logic [7:0] anim_tick, anim_pattern;

  acgc_glide_axis u_axis_x (
    .fine_i   (fine_x_q),
    .target_i (target_x_q),
    .fine_o   (ax_fine_x),
    .cursor_o (ax_cur_x),
    .snap_o   (snap_x)
  );

  acgc_glide_axis u_axis_y (
    .fine_i   (fine_y_q),
    .target_i (target_y_q),
    .fine_o   (ax_fine_y),
    .cursor_o (ax_cur_y),
    .snap_o   (snap_y)
  );

  acgc_anim_step u_anim (
    .tick_i    (tick_q),
    .pattern_i (pattern_q),
    .speed_i   (cfg.anim_speed),
    .count_i   (cfg.pattern_count),
    .tick_o    (anim_tick),
    .pattern_o (anim_pattern)
  );

  always_comb begin
    tick_d       = tick_q;
    pattern_d    = pattern_q;
    fine_x_d     = fine_x_q;
    fine_y_d     = fine_y_q;
    target_x_d   = target_x_q;
    target_y_d   = target_y_q;
    cursor_x_d   = cursor_x_q;
    cursor_y_d   = cursor_y_q;
    glide_d      = glide_q;
    left_prev_d  = left_prev_q;
    right_prev_d = right_prev_q;
    flags_d      = flags_q;
    warp         = 1'b0;
    if (in_action_q == ACTION_GLIDE) begin
      // Latch the goal and start from the current pixel, fraction zero.
      target_x_d = goal_x;
      target_y_d = goal_y;
      fine_x_d   = fine_t'({cursor_x_q, {FRAC_BITS{1'b0}}});
      fine_y_d   = fine_t'({cursor_y_q, {FRAC_BITS{1'b0}}});
      glide_d    = 1'b1;
      flags_d    = '0;
    end else begin
      if (glide_q) begin
        fine_x_d   = ax_fine_x;
        fine_y_d   = ax_fine_y;
        cursor_x_d = ax_cur_x;
        cursor_y_d = ax_cur_y;
        if (snap_x && snap_y) begin
          glide_d = 1'b0;
          warp    = 1'b1;
        end
      end else begin
        cursor_x_d = mouse_x;
        cursor_y_d = mouse_y;
        flags_d    = '0;
        flags_d[FLAG_LEFT_HELD]  = left_lvl;
        flags_d[FLAG_RIGHT_HELD] = right_lvl;
        flags_d[FLAG_LEFT_DOWN]  = left_lvl && !left_prev_q;
        flags_d[FLAG_LEFT_UP]    = !left_lvl && left_prev_q;
        flags_d[FLAG_RIGHT_DOWN] = right_lvl && !right_prev_q;
        flags_d[FLAG_RIGHT_UP]   = !right_lvl && right_prev_q;
        left_prev_d  = left_lvl;
        right_prev_d = right_lvl;
      end
      tick_d    = anim_tick;
      pattern_d = anim_pattern;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q       <= '0;
      pattern_q    <= '0;
      fine_x_q     <= '0;
      fine_y_q     <= '0;
      target_x_q   <= '0;
      target_y_q   <= '0;
      cursor_x_q   <= '0;
      cursor_y_q   <= '0;
      glide_q      <= 1'b0;
      left_prev_q  <= 1'b0;
      right_prev_q <= 1'b0;
      flags_q      <= '0;
    end else begin
      if (fire) begin
        tick_q       <= tick_d;
        pattern_q    <= pattern_d;
        fine_x_q     <= fine_x_d;
        fine_y_q     <= fine_y_d;
        target_x_q   <= target_x_d;
        target_y_q   <= target_y_d;
        cursor_x_q   <= cursor_x_d;
        cursor_y_q   <= cursor_y_d;
        glide_q      <= glide_d;
        left_prev_q  <= left_prev_d;
        right_prev_q <= right_prev_d;
        flags_q      <= flags_d;
      end
      // A new pattern count restarts the animation and ends any glide.
      if (restart) begin
        tick_q    <= '0;
        pattern_q <= '0;
        glide_q   <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {warp, glide_d, flags_d, pattern_d,
                     draw_pos(cursor_y_d, cfg.hotspot_y),
                     draw_pos(cursor_x_d, cfg.hotspot_x),
                     coord_to_16(cursor_y_d), coord_to_16(cursor_x_d)};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_data_q};

  // The warp flag only comes with the glide being over.
  a_warp_ends_glide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q[81] && out_data_q[80]))
    else $error("warp shown while still gliding");

  // The pattern index stays below the pattern count.
  a_pattern_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pattern_q < cfg.pattern_count)
    else $error("pattern index out of range");

  // A glide command leaves glide on and the flags cleared.
  a_glide_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_action_q == ACTION_GLIDE && !restart) |=> (glide_q && flags_q == 6'd0))
    else $error("glide command did not start glide");

  // A result that is stalled keeps its contents.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("stalled result changed");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the animated cursor glide controller.
`timescale 1ns / 1ps

module tb_top;
  import acgc_pkg::*;

  // Sub-pixel scale of the glide arithmetic.
  localparam longint PIXEL = longint'(1) << FRAC_BITS;

  // One input transaction. Declared from the top bit down, so that the low 66 bits
  // match the slave tdata layout and the action rides in tuser.
  typedef struct packed {
    logic        action;
    logic [15:0] goal_y;
    logic [15:0] goal_x;
    logic        right;
    logic        left;
    logic [15:0] mouse_y;
    logic [15:0] mouse_x;
  } cursor_cmd_t;

  // One result transaction, laid out exactly as the low 82 bits of master tdata.
  typedef struct packed {
    logic        warp;
    logic        gliding;
    logic [5:0]  flags;
    logic [7:0]  pattern;
    logic [16:0] draw_y;
    logic [16:0] draw_x;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
  } cursor_view_t;

  // A row of the directed table. When typed is set, want is the expected
  // result copied straight from the specification instead of the predictor.
  typedef struct packed {
    logic         typed;
    cursor_view_t want;
    cursor_cmd_t  cmd;
  } stim_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i  = '0;
  logic [0:0]  s_axis_tuser_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [87:0] m_axis_tdata_o;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [3:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;

  animated_cursor_glide_controller u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: the register values as written, and the cursor state that
  // the block is expected to hold after every accepted transaction.
  cfg_t        set_regs;
  logic [7:0]  tick_ctr   = '0;
  logic [7:0]  frame_no   = '0;
  longint      sub_x      = 0;
  longint      sub_y      = 0;
  coord_t      aim_x      = '0;
  coord_t      aim_y      = '0;
  coord_t      spot_x     = '0;
  coord_t      spot_y     = '0;
  logic        in_glide   = 1'b0;
  logic        prev_left  = 1'b0;
  logic        prev_right = 1'b0;
  logic [5:0]  btn_flags  = '0;

  // Results still owed by the block, oldest first.
  cursor_view_t expected_views[$];

  int fault_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Set by the stimulus thread to ask the receiver for a long stall; the
  // receiver counts the stall down in its own process.
  int hold_request  = 0;
  int hold_left     = 0;

  logic [15:0] corner_vals [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

  task automatic log_mismatch(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t ns: mismatch: %s", $realtime, msg);
  endtask

  function automatic string show_view(cursor_view_t v);
    return $sformatf("pos=(%0d,%0d) draw=(%0d,%0d) pattern=%0d buttons=%02h glide=%0b warp=%0b",
                     $signed(v.pos_x), $signed(v.pos_y), $signed(v.draw_x), $signed(v.draw_y),
                     v.pattern, v.flags, v.gliding, v.warp);
  endfunction

  function automatic cursor_view_t view(logic [15:0] px, logic [15:0] py, logic [16:0] dx,
                                        logic [16:0] dy, logic [7:0] pat, logic [5:0] fl,
                                        logic g, logic w);
    cursor_view_t v;
    v.pos_x   = px;
    v.pos_y   = py;
    v.draw_x  = dx;
    v.draw_y  = dy;
    v.pattern = pat;
    v.flags   = fl;
    v.gliding = g;
    v.warp    = w;
    return v;
  endfunction

  function automatic stim_row_t stim_row(logic act, logic [15:0] mx, logic [15:0] my, logic l,
                                         logic r, logic [15:0] gx, logic [15:0] gy,
                                         logic typed, cursor_view_t want);
    stim_row_t s;
    s.cmd.action  = act;
    s.cmd.mouse_x = mx;
    s.cmd.mouse_y = my;
    s.cmd.left    = l;
    s.cmd.right   = r;
    s.cmd.goal_x  = gx;
    s.cmd.goal_y  = gy;
    s.typed       = typed;
    s.want        = want;
    return s;
  endfunction

  // One axis of a glide tick: move half the remaining distance, but at least
  // one pixel, or snap to the goal once within a pixel. Returns 1 on a snap.
  task automatic glide_axis(inout longint sub, input coord_t goal, inout coord_t pix,
                            output bit snapped);
    longint remain;
    longint half;
    remain  = longint'(goal) * PIXEL - sub;
    half    = remain / 2;
    snapped = 1'b0;
    if (remain > PIXEL) begin
      sub += (half > PIXEL) ? half : PIXEL;
      pix  = coord_t'(sub >>> FRAC_BITS);
    end else if (remain < -PIXEL) begin
      sub += (half < -PIXEL) ? half : -PIXEL;
      pix  = coord_t'(sub >>> FRAC_BITS);
    end else begin
      // A snapped axis keeps its sub-pixel position untouched.
      pix     = goal;
      snapped = 1'b1;
    end
  endtask

  // Applies one accepted transaction to the predictor state and forms the result.
  task automatic advance_cursor(input cursor_cmd_t c, output cursor_view_t v);
    logic [5:0] f;
    bit         snap_x;
    bit         snap_y;
    logic       arrived;
    int         spd;
    int         mag;
    longint     dx;
    longint     dy;
    arrived = 1'b0;
    if (c.action == ACTION_GLIDE) begin
      // Latch the goal and start from the current pixel; animation holds still.
      aim_x     = coord_t'($signed(c.goal_x));
      aim_y     = coord_t'($signed(c.goal_y));
      sub_x     = longint'(spot_x) * PIXEL;
      sub_y     = longint'(spot_y) * PIXEL;
      in_glide  = 1'b1;
      btn_flags = '0;
    end else begin
      if (in_glide) begin
        // Buttons are ignored while gliding.
        glide_axis(sub_x, aim_x, spot_x, snap_x);
        glide_axis(sub_y, aim_y, spot_y, snap_y);
        if (snap_x && snap_y) begin
          in_glide = 1'b0;
          arrived  = 1'b1;
        end
      end else begin
        spot_x              = coord_t'($signed(c.mouse_x));
        spot_y              = coord_t'($signed(c.mouse_y));
        f                   = '0;
        f[FLAG_LEFT_HELD]   = c.left;
        f[FLAG_RIGHT_HELD]  = c.right;
        f[FLAG_LEFT_DOWN]   = c.left & ~prev_left;
        f[FLAG_LEFT_UP]     = ~c.left & prev_left;
        f[FLAG_RIGHT_DOWN]  = c.right & ~prev_right;
        f[FLAG_RIGHT_UP]    = ~c.right & prev_right;
        btn_flags           = f;
        prev_left           = c.left;
        prev_right          = c.right;
      end
      spd      = int'($signed(set_regs.anim_speed));
      mag      = (spd < 0) ? -spd : spd;
      tick_ctr = tick_ctr + 8'd1;
      if (spd != 0 && int'(tick_ctr) >= mag) begin
        if (spd > 0)
          frame_no = 8'((int'(frame_no) + 1) % int'(set_regs.pattern_count));
        else
          frame_no = 8'((int'(frame_no) + int'(set_regs.pattern_count) - 1)
                        % int'(set_regs.pattern_count));
        tick_ctr = '0;
      end
    end
    dx        = longint'(spot_x) - longint'($signed(set_regs.hotspot_x));
    dy        = longint'(spot_y) - longint'($signed(set_regs.hotspot_y));
    v.pos_x   = 16'(spot_x);
    v.pos_y   = 16'(spot_y);
    v.draw_x  = dx[16:0];
    v.draw_y  = dy[16:0];
    v.pattern = frame_no;
    v.flags   = btn_flags;
    v.gliding = in_glide;
    v.warp    = arrived;
  endtask

  // Offers one transaction on the slave stream, with random idle cycles first.
  // Returns at the edge that accepted it, with tvalid still high, so that the
  // next call can keep it high without a gap. While idle, tdata carries junk.
  task automatic send_item(input cursor_cmd_t c, input logic typed, input cursor_view_t want);
    cursor_view_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= {8'($urandom), $urandom, $urandom};
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'd0, c[65:0]};
    s_axis_tuser_i  <= c.action;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    advance_cursor(c, predicted);
    expected_views.push_back(typed ? want : predicted);
  endtask

  // Drops tvalid and waits until every owed result has come back, with a bound.
  task automatic wait_for_results();
    int spins;
    spins = 0;
    s_axis_tvalid_i <= 1'b0;
    while (expected_views.size() != 0 && spins < 50000) begin
      @(posedge clk_i);
      spins++;
    end
  endtask

  // APB write: the setup phase, then the access phase held until pready, then
  // the bus returns to idle.
  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PATTERN_COUNT: begin
        // A zero count is dropped and restarts nothing.
        if (value[7:0] != 8'd0) begin
          set_regs.pattern_count = value[7:0];
          tick_ctr               = '0;
          frame_no               = '0;
          in_glide               = 1'b0;
        end
      end
      REG_ANIM_SPEED: set_regs.anim_speed = value[7:0];
      REG_HOTSPOT_X:  set_regs.hotspot_x  = value[15:0];
      REG_HOTSPOT_Y:  set_regs.hotspot_y  = value[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Receiver side. Every accepted result is compared field by field with the
  // oldest expectation; then tready is chosen for the next cycle, either by
  // the random idle rate or by a pending long stall.
  always @(posedge clk_i) begin : result_side
    cursor_view_t seen;
    cursor_view_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      seen = m_axis_tdata_o[81:0];
      if (expected_views.size() == 0) begin
        log_mismatch($sformatf("unexpected result %s", show_view(seen)));
      end else begin
        want = expected_views.pop_front();
        if (seen.pos_x !== want.pos_x || seen.pos_y !== want.pos_y ||
            seen.draw_x !== want.draw_x || seen.draw_y !== want.draw_y ||
            seen.pattern !== want.pattern || seen.flags !== want.flags ||
            seen.gliding !== want.gliding || seen.warp !== want.warp) begin
          log_mismatch($sformatf("expected %s, got %s", show_view(want), show_view(seen)));
        end
      end
    end
    if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left--;
    end else if (hold_request > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left    = hold_request - 1;
      hold_request = 0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Stimulus: reset, a directed table, then four random phases, each under
  // its own register setting; the last two share one idle pattern.
  initial begin : stimulus
    stim_row_t    dir_rows[$];
    cursor_cmd_t  c;
    cursor_view_t none;
    logic [31:0]  count_set [4];
    logic [31:0]  speed_set [4];
    logic [31:0]  hotx_set [4];
    logic [31:0]  hoty_set [4];
    int           ph;
    int           n;
    int           pick;

    set_regs               = '0;
    set_regs.pattern_count = 8'd1;
    none                   = '0;
    send_idle_pct          = 6;
    recv_idle_pct          = 75;

    // Rows with a typed result follow from reset values and the default
    // registers (one pattern, speed zero, hotspot at the origin).
    // Extremes of the mouse fields and every press/release pattern come first.
    dir_rows.push_back(stim_row(ACTION_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000,
                                16'h0000, 1'b1, view(16'h0000, 16'h0000, 17'h00000,
                                17'h00000, 8'd0, 6'h00, 1'b0, 1'b0)));
    dir_rows.push_back(stim_row(ACTION_TICK, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'hAAAA,
                                16'h5555, 1'b1, view(16'h7FFF, 16'h8000, 17'h07FFF,
                                17'h18000, 8'd0, 6'h17, 1'b0, 1'b0)));
    dir_rows.push_back(stim_row(ACTION_TICK, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 16'h5555,
                                16'hAAAA, 1'b1, view(16'h8000, 16'h7FFF, 17'h18000,
                                17'h07FFF, 8'd0, 6'h21, 1'b0, 1'b0)));
    dir_rows.push_back(stim_row(ACTION_TICK, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF,
                                16'hFFFF, 1'b1, view(16'hFFFF, 16'hFFFF, 17'h1FFFF,
                                17'h1FFFF, 8'd0, 6'h1A, 1'b0, 1'b0)));
    // A glide to where the cursor already is: flags clear, then the next tick
    // snaps both axes at once and raises the warp.
    dir_rows.push_back(stim_row(ACTION_GLIDE, 16'h1234, 16'h4321, 1'b1, 1'b0, 16'hFFFF,
                                16'hFFFF, 1'b1, view(16'hFFFF, 16'hFFFF, 17'h1FFFF,
                                17'h1FFFF, 8'd0, 6'h00, 1'b1, 1'b0)));
    dir_rows.push_back(stim_row(ACTION_TICK, 16'h5555, 16'hAAAA, 1'b1, 1'b1, 16'h0000,
                                16'h0000, 1'b1, view(16'hFFFF, 16'hFFFF, 17'h1FFFF,
                                17'h1FFFF, 8'd0, 6'h00, 1'b0, 1'b1)));
    // A short glide on x only: y is snapped from the start, x takes the
    // half step, then the one pixel minimum, then snaps.
    dir_rows.push_back(stim_row(ACTION_TICK, 16'h0064, 16'h00C8, 1'b0, 1'b0, 16'h0000,
                                16'h0000, 1'b0, none));
    dir_rows.push_back(stim_row(ACTION_GLIDE, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0067,
                                16'h00C8, 1'b0, none));
    dir_rows.push_back(stim_row(ACTION_TICK, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 16'hAAAA,
                                16'hAAAA, 1'b0, none));
    dir_rows.push_back(stim_row(ACTION_TICK, 16'h8000, 16'h8000, 1'b0, 1'b1, 16'h5555,
                                16'h5555, 1'b0, none));
    dir_rows.push_back(stim_row(ACTION_TICK, 16'h1111, 16'h2222, 1'b1, 1'b0, 16'h0000,
                                16'h0000, 1'b0, none));
    dir_rows.push_back(stim_row(ACTION_TICK, 16'h8000, 16'h7FFF, 1'b1, 1'b1, 16'h0000,
                                16'h0000, 1'b0, none));
    // A long glide to the opposite corner, retargeted before it arrives.
    dir_rows.push_back(stim_row(ACTION_GLIDE, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h7FFF,
                                16'h8000, 1'b0, none));
    dir_rows.push_back(stim_row(ACTION_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000,
                                16'h0000, 1'b0, none));
    dir_rows.push_back(stim_row(ACTION_TICK, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0000,
                                16'h0000, 1'b0, none));
    dir_rows.push_back(stim_row(ACTION_TICK, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0000,
                                16'h0000, 1'b0, none));
    dir_rows.push_back(stim_row(ACTION_GLIDE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'h0000,
                                16'h0000, 1'b0, none));
    dir_rows.push_back(stim_row(ACTION_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000,
                                16'h0000, 1'b0, none));

    // Register settings per random phase. The third writes a zero count,
    // which must leave the count of 255 and the animation running as they are.
    count_set = '{32'd5, 32'd255, 32'd0, 32'd3};
    speed_set = '{32'd127, 32'hFFFF_FF80, 32'hFFFF_FFFF, 32'd2};
    hotx_set  = '{32'hFFFF_8000, 32'h0000_7FFF, {16'h0, 16'($urandom)}, {16'h0, 16'($urandom)}};
    hoty_set  = '{32'h0000_7FFF, 32'hFFFF_8000, {16'h0, 16'($urandom)}, {16'h0, 16'($urandom)}};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

    for (ph = 0; ph < 4; ph++) begin
      // Registers change only with nothing in flight.
      wait_for_results();
      apb_write(REG_PATTERN_COUNT, count_set[ph]);
      apb_write(REG_ANIM_SPEED, speed_set[ph]);
      apb_write(REG_HOTSPOT_X, hotx_set[ph]);
      apb_write(REG_HOTSPOT_Y, hoty_set[ph]);
      case (ph)
        0: begin send_idle_pct = 6;  recv_idle_pct = 75; end
        1: begin send_idle_pct = 75; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (n = 0; n < 190; n++) begin
        // Once the sender pauses until the block has emptied; once the receiver
        // stalls long enough that the block backs up into its input.
        if (ph == 0 && n == 95) wait_for_results();
        if (ph == 2 && n == 60) hold_request = 60;

        c.action  = ACTION_TICK;
        c.mouse_x = 16'($urandom);
        c.mouse_y = 16'($urandom);
        pick      = $urandom_range(0, 15);
        if (pick < 4) c.mouse_x = corner_vals[pick];
        pick      = $urandom_range(0, 15);
        if (pick < 4) c.mouse_y = corner_vals[pick];
        c.left    = 1'($urandom_range(0, 1));
        c.right   = 1'($urandom_range(0, 1));
        c.goal_x  = 16'($urandom);
        c.goal_y  = 16'($urandom);

        // Mostly ticks, with glide commands often enough that most glides run
        // to their arrival and some are retargeted midway.
        if ($urandom_range(0, 99) < (in_glide ? 6 : 14)) begin
          c.action = ACTION_GLIDE;
          pick     = $urandom_range(0, 9);
          if (pick == 0) begin
            c.goal_x = 16'(spot_x);
            c.goal_y = 16'(spot_y);
          end else if (pick == 1) begin
            c.goal_x = 16'(int'(spot_x) + ($urandom_range(0, 1) ? 1 : -1));
            c.goal_y = 16'(spot_y);
          end else if (pick < 6) begin
            c.goal_x = 16'(int'(spot_x) + int'($urandom_range(0, 2000)) - 1000);
            c.goal_y = 16'(int'(spot_y) + int'($urandom_range(0, 2000)) - 1000);
          end else if (pick == 6) begin
            c.goal_x = corner_vals[$urandom_range(0, 1)];
            c.goal_y = corner_vals[$urandom_range(0, 1)];
          end else if (pick == 7) begin
            c.goal_y = 16'(spot_y);
          end
        end
        send_item(c, 1'b0, none);
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (expected_views.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", expected_views.size()));
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
